/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// plain invariant
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, expr)

`endif

`endif

/* sv/firtt_pkg.sv */
// ----------------------------------------------------------------------------
// firtt_pkg
// Types, constants and coefficient tables of the two-table FIR filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package firtt_pkg;

   // field widths
   localparam int SampleW  = 16;
   localparam int CoefW    = 17;
   localparam int ProdW    = SampleW + CoefW;
   localparam int OutW     = 17;
   localparam int FracBits = 16;
   localparam int TableLen = 10;

   // filter_mode codes
   localparam logic MODE_HIGH_PASS = 1'b0;
   localparam logic MODE_LOW_PASS  = 1'b1;

   // Q16 coefficient tables, entry 0 weights the oldest sample
   localparam logic signed [CoefW-1:0] CoefHigh [TableLen] = '{
      -17'sd5964, -17'sd5964, -17'sd5964, -17'sd5964, -17'sd5964,
      -17'sd5964, -17'sd5964, -17'sd5964, -17'sd5964, 17'sd59648
   };
   localparam logic signed [CoefW-1:0] CoefLow [TableLen] = '{
      17'sd10896, 17'sd4672, 17'sd5333, 17'sd5809, 17'sd6057,
      17'sd6057, 17'sd5809, 17'sd5333, 17'sd4672, 17'sd10896
   };

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_FLUSH,
      ST_ROUND
   } state_type;

   // sequencer strobes
   typedef struct packed {
      logic load;      // shift sample in, clear accumulator
      logic mul_en;    // issue one tap product
      logic out_load;  // capture rounded result
   } ctrl_type;

   // weight of table entry e; zero where the entry does not exist
   function automatic logic signed [CoefW-1:0] coef_lookup(input logic mode, input int e);
      logic signed [CoefW-1:0] w;
      logic [3:0]              idx;
      begin
         w   = '0;
         idx = 4'(e);
         if (e >= 0 && e < TableLen) begin
            if (mode == MODE_LOW_PASS) begin
               w = CoefLow[idx];
            end else begin
               w = CoefHigh[idx];
            end
         end
         return w;
      end
   endfunction

endpackage

`default_nettype wire

/* sv/firtt_delay_line.sv */
// ----------------------------------------------------------------------------
// firtt_delay_line
// Sample history; newest at the top index, read one tap per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module firtt_delay_line #(
   parameter int TAPS  = 10,
   parameter int IDX_W = 4
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 shift_en,
   input  wire logic signed [firtt_pkg::SampleW-1:0] shift_data,
   input  wire logic [IDX_W-1:0]                     rd_idx,
   output logic signed [firtt_pkg::SampleW-1:0]      rd_data
);

   logic signed [firtt_pkg::SampleW-1:0] dl_ff [TAPS];

   // shift toward index 0, new word enters at the top
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) dl_ff[i] <= '0;
      end else if (shift_en) begin
         for (int i = 0; i < TAPS - 1; i++) dl_ff[i] <= dl_ff[i+1];
         dl_ff[TAPS-1] <= shift_data;
      end
   end

   // tap read mux
   assign rd_data = dl_ff[rd_idx];

endmodule

`default_nettype wire

/* sv/firtt_mac.sv */
// ----------------------------------------------------------------------------
// firtt_mac
// Shared multiply-accumulate with registered product, plus round/saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module firtt_mac #(
   parameter int ACC_W = 38
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 clear,
   input  wire logic                                 mul_en,
   input  wire logic signed [firtt_pkg::SampleW-1:0] sample,
   input  wire logic signed [firtt_pkg::CoefW-1:0]   coef,
   output logic signed [firtt_pkg::OutW-1:0]         rounded
);

   localparam int PW = firtt_pkg::ProdW;
   localparam logic signed [ACC_W:0] Half  = (ACC_W+1)'(2 ** (firtt_pkg::FracBits - 1));
   localparam logic signed [ACC_W:0] SatHi = (ACC_W+1)'(2 ** (firtt_pkg::OutW - 1) - 1);
   localparam logic signed [ACC_W:0] SatLo = -SatHi - (ACC_W+1)'(1);

   logic signed [PW-1:0]    prod_ff;
   logic                    prod_vld_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W:0]   biased;
   logic signed [ACC_W:0]   quot;

   // multiplier stage
   always_ff @(posedge clock) begin
      prod_ff <= sample * coef;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= mul_en;
      end
   end

   // accumulate the registered product
   always_comb begin
      acc_in = acc_ff;
      if (prod_vld_ff) begin
         acc_in = acc_ff + {{(ACC_W-PW){prod_ff[PW-1]}}, prod_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   // add one half, divide by 2^16 truncating toward zero, saturate
   always_comb begin
      biased = {acc_ff[ACC_W-1], acc_ff} + Half;
      quot   = biased >>> firtt_pkg::FracBits;
      if (biased[ACC_W] && (|biased[firtt_pkg::FracBits-1:0])) begin
         quot = quot + (ACC_W+1)'(1);
      end
      if (quot > SatHi) begin
         rounded = firtt_pkg::OutW'(SatHi);
      end else if (quot < SatLo) begin
         rounded = firtt_pkg::OutW'(SatLo);
      end else begin
         rounded = quot[firtt_pkg::OutW-1:0];
      end
   end

endmodule

`default_nettype wire

/* sv/firtt_ctrl.sv */
// ----------------------------------------------------------------------------
// firtt_ctrl
// Sequencer: load, one tap product per cycle, drain, round and hand off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module firtt_ctrl #(
   parameter int TAPS  = 10,
   parameter int IDX_W = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 out_free,
   output firtt_pkg::ctrl_type       ctrl,
   output logic [IDX_W-1:0]          tap_idx,
   output logic                      busy
);

   localparam logic [IDX_W-1:0] LastTap = IDX_W'(TAPS - 1);

   firtt_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]     cnt_ff, cnt_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         firtt_pkg::ST_IDLE:  if (req_valid) state_in = firtt_pkg::ST_MAC;
         firtt_pkg::ST_MAC:   if (cnt_ff == LastTap) state_in = firtt_pkg::ST_FLUSH;
         firtt_pkg::ST_FLUSH: state_in = firtt_pkg::ST_ROUND;
         firtt_pkg::ST_ROUND: if (out_free) state_in = firtt_pkg::ST_IDLE;
         default:             state_in = firtt_pkg::ST_IDLE;
      endcase
   end

   // tap counter
   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == firtt_pkg::ST_IDLE) begin
         cnt_in = '0;
      end else if (state_ff == firtt_pkg::ST_MAC && cnt_ff != LastTap) begin
         cnt_in = cnt_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= firtt_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // strobes
   always_comb begin
      ctrl = '0;
      case (state_ff)
         firtt_pkg::ST_IDLE:  ctrl.load     = req_valid;
         firtt_pkg::ST_MAC:   ctrl.mul_en   = 1'b1;
         firtt_pkg::ST_FLUSH: ctrl          = '0;
         firtt_pkg::ST_ROUND: ctrl.out_load = out_free;
         default:             ctrl          = '0;
      endcase
   end

   assign tap_idx = cnt_ff;
   assign busy    = (state_ff != firtt_pkg::ST_IDLE);

endmodule

`default_nettype wire

/* sv/fir_filter_two_table_core.sv */
// ----------------------------------------------------------------------------
// fir_filter_two_table_core
// TAPS-tap FIR filter with selectable high-pass / low-pass Q16 tables.
// ----------------------------------------------------------------------------
// Each accepted sample word is shifted into the delay line; in ST_MAC the
// single shared 16x17 multiplier forms the TAPS tap products in turn,
// ST_FLUSH adds the last one and ST_ROUND rounds once the output register is
// free; the result stays there until taken. The next sample is accepted as
// soon as the result is captured, even if the consumer still stalls it;
// only a second finished result waits. The user must write filter_mode
// (csr_filter_mode, 0 high-pass, 1 low-pass) only while idle; not enforced.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fir_filter_two_table_core #(
   parameter int TAPS = 10
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // input channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [firtt_pkg::SampleW-1:0] req_sample,
   // result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [firtt_pkg::OutW-1:0]         rsp_filtered,
   // configuration
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic                                 csr_filter_mode
);

   localparam int IDX_W = $clog2(TAPS);
   localparam int ACC_W = firtt_pkg::ProdW + $clog2(TAPS) + 1;

   firtt_pkg::ctrl_type                  ctrl;
   logic [IDX_W-1:0]                     tap_idx;
   logic                                 busy;
   logic                                 out_free;
   logic                                 filter_mode_ff;
   logic signed [firtt_pkg::SampleW-1:0] tap_sample;
   logic signed [firtt_pkg::CoefW-1:0]   tap_coef;
   logic signed [firtt_pkg::OutW-1:0]    rounded;
   logic                                 rsp_valid_ff;
   logic signed [firtt_pkg::OutW-1:0]    rsp_filtered_ff;

   // mode register, no writes taken during reset
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff <= firtt_pkg::MODE_HIGH_PASS;
      end else if (csr_valid && csr_ready) begin
         filter_mode_ff <= csr_filter_mode;
      end
   end

   // output register is free when empty or being taken
   assign out_free = !rsp_valid_ff || !rsp_stall;

   firtt_ctrl #(
      .TAPS  (TAPS),
      .IDX_W (IDX_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .ctrl      (ctrl),
      .tap_idx   (tap_idx),
      .busy      (busy)
   );

   // input held off while working and during reset
   assign req_stall = busy || reset;

   firtt_delay_line #(
      .TAPS  (TAPS),
      .IDX_W (IDX_W)
   ) u_delay_line (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (ctrl.load),
      .shift_data (req_sample),
      .rd_idx     (tap_idx),
      .rd_data    (tap_sample)
   );

   // tap k uses table entry k + 10 - TAPS
   assign tap_coef = firtt_pkg::coef_lookup(filter_mode_ff,
                        int'(tap_idx) + firtt_pkg::TableLen - TAPS);

   firtt_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .clear   (ctrl.load),
      .mul_en  (ctrl.mul_en),
      .sample  (tap_sample),
      .coef    (tap_coef),
      .rounded (rounded)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_filtered_ff <= rounded;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   // checks
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   `ASSERT_SAME(a_no_overwrite, clock, reset, ctrl.out_load, !rsp_valid_ff || !rsp_stall)
   `ASSERT_NEXT(a_taken_clears, clock, reset,
      rsp_valid && !rsp_stall && !ctrl.out_load, !rsp_valid)
   `ASSERT_ALWAYS(a_one_strobe, clock, reset, $onehot0({ctrl.load, ctrl.mul_en, ctrl.out_load}))

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for fir_filter_two_table_core. A local predictor keeps
// its own delay line and table select. It forms the expected filtered word for
// every accepted sample. A monitor compares each result word in order. Both
// channels idle at random. One phase fills the block behind a long result
// stall. Both coefficient tables are exercised, directed and random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int Taps         = 10;
   localparam int TableEntries = 10;
   localparam int Latency      = Taps + 3;
   localparam int MaxReports   = 10;

   logic                                     clock           = 1'b0;
   logic                                     reset           = 1'b1;
   logic                                     req_valid       = 1'b0;
   logic                                     req_stall;
   logic signed [firtt_pkg::SampleW-1:0]     req_sample      = '0;
   logic                                     rsp_valid;
   logic                                     rsp_stall       = 1'b0;
   logic signed [firtt_pkg::OutW-1:0]        rsp_filtered;
   logic                                     csr_valid       = 1'b0;
   logic                                     csr_ready;
   logic                                     csr_filter_mode = firtt_pkg::MODE_HIGH_PASS;

   // predictor state
   logic signed [firtt_pkg::SampleW-1:0]     sample_hist [Taps];
   logic                                     pred_mode;
   logic signed [firtt_pkg::OutW-1:0]        expected_filtered [$];

   int error_count   = 0;
   int hold_request  = 0;
   bit req_gaps_on   = 1'b1;
   bit rsp_gaps_on   = 1'b1;

   fir_filter_two_table_core #(
      .TAPS(Taps)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_filtered    (rsp_filtered),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_filter_mode (csr_filter_mode)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Q16 weight of tap k (0 = oldest); taps without a table entry weigh zero
   function automatic longint tap_coef(input logic mode, input int k);
      int     e;
      longint w;
      e = k + TableEntries - Taps;
      w = 0;
      if (e >= 0 && e < TableEntries) begin
         if (mode == firtt_pkg::MODE_LOW_PASS) begin
            case (e)
               0, 9:    w = 10896;
               1, 8:    w = 4672;
               2, 7:    w = 5333;
               3, 6:    w = 5809;
               default: w = 6057;
            endcase
         end else begin
            w = (e == TableEntries - 1) ? 59648 : -5964;
         end
      end
      return w;
   endfunction

   // shift one sample in, then weighted sum plus one half, truncated toward zero, saturated
   function automatic logic signed [firtt_pkg::OutW-1:0] shift_and_filter(
      input logic signed [firtt_pkg::SampleW-1:0] s);
      longint acc;
      longint y;
      acc = 0;
      for (int k = 0; k < Taps - 1; k++) sample_hist[k] = sample_hist[k + 1];
      sample_hist[Taps - 1] = s;
      for (int k = 0; k < Taps; k++) acc += tap_coef(pred_mode, k) * longint'(sample_hist[k]);
      y = (acc + 32768) / 65536;
      if (y > 65535) y = 65535;
      if (y < -65536) y = -65536;
      return y[firtt_pkg::OutW-1:0];
   endfunction

   // sample source: uniform, extremes-heavy, or slow drift like a pulse trace
   function automatic logic signed [firtt_pkg::SampleW-1:0] pick_sample(
      input int style, input logic signed [firtt_pkg::SampleW-1:0] prev);
      logic signed [firtt_pkg::SampleW-1:0] s;
      s = 16'($urandom);
      if (style == 1) begin
         case ($urandom_range(0, 5))
            0: s = 16'sh7FFF;
            1: s = 16'sh8000;
            2: s = 16'sh0000;
            3: s = 16'sh0001;
            4: s = 16'shFFFF;
            default: s = 16'($urandom);
         endcase
      end else if (style == 2) begin
         s = prev + 16'($urandom_range(0, 512)) - 16'sd256;
      end
      return s;
   endfunction

   // offer one sample word until taken, then maybe idle
   task automatic send_sample(input logic signed [firtt_pkg::SampleW-1:0] s);
      int gap;
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_filtered.push_back(shift_and_filter(s));
      if (req_gaps_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold the sender until every expected word is back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_filtered.size() != 0) @(posedge clock);
      repeat (Latency) @(posedge clock);
   endtask

   task automatic write_filter_mode(input logic mode);
      csr_valid       <= 1'b1;
      csr_filter_mode <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pred_mode = mode;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // reset default is high-pass; extremes through a cleared delay line
   task automatic test_high_pass_directed();
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(16'sh8000);
      send_sample(16'sh0001);
      send_sample(16'shFFFF);
      send_sample(16'sh0000);
      drain_results();
   endtask

   // low-pass: one negative extreme, then positive extremes until the line is full
   task automatic test_low_pass_directed();
      write_filter_mode(firtt_pkg::MODE_LOW_PASS);
      send_sample(16'sh8000);
      repeat (9) send_sample(16'sh7FFF);
      drain_results();
   endtask

   // back to high-pass with alternating extremes
   task automatic test_mode_return();
      write_filter_mode(firtt_pkg::MODE_HIGH_PASS);
      for (int i = 0; i < 5; i++) send_sample(i[0] ? 16'sh8000 : 16'sh7FFF);
      drain_results();
   endtask

   // result side holds off long enough for the block to stall its input
   task automatic test_stall_fill();
      req_gaps_on  = 1'b0;
      rsp_gaps_on  = 1'b0;
      hold_request = 300;
      for (int i = 0; i < 20; i++) send_sample(16'($urandom));
      drain_results();
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
   endtask

   // phases of random samples under both tables and mixed idling
   task automatic test_random_phases();
      logic                                 mode;
      logic signed [firtt_pkg::SampleW-1:0] s;
      s = '0;
      for (int p = 0; p < 8; p++) begin
         if (p < 2) begin
            mode = p[0] ? firtt_pkg::MODE_LOW_PASS : firtt_pkg::MODE_HIGH_PASS;
         end else begin
            mode = $urandom_range(0, 1) ? firtt_pkg::MODE_LOW_PASS : firtt_pkg::MODE_HIGH_PASS;
         end
         write_filter_mode(mode);
         req_gaps_on = (p % 3 != 2);
         rsp_gaps_on = (p % 4 != 1);
         for (int i = 0; i < 120; i++) begin
            s = pick_sample(p % 3, s);
            send_sample(s);
         end
         drain_results();
      end
   endtask

   // closing stretch at full rate, no idling on either side
   task automatic test_back_to_back();
      logic signed [firtt_pkg::SampleW-1:0] s;
      s = '0;
      req_gaps_on = 1'b0;
      rsp_gaps_on = 1'b0;
      write_filter_mode($urandom_range(0, 1) ? firtt_pkg::MODE_LOW_PASS
                                              : firtt_pkg::MODE_HIGH_PASS);
      for (int i = 0; i < 150; i++) begin
         s = pick_sample(i % 3, s);
         send_sample(s);
      end
      drain_results();
   endtask

   // result side: check each taken word, then decide the next stall
   initial begin : result_monitor
      int                                burst_left;
      int                                hold_left;
      logic signed [firtt_pkg::OutW-1:0] want;
      burst_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_filtered.size() == 0) begin
               error_count++;
               if (error_count <= MaxReports) begin
                  $display("unexpected result word: got %0d", rsp_filtered);
               end
            end else begin
               want = expected_filtered.pop_front();
               if (rsp_filtered !== want) begin
                  error_count++;
                  if (error_count <= MaxReports) begin
                     $display("filtered mismatch: expected %0d got %0d", want, rsp_filtered);
                  end
               end
            end
         end
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_gaps_on && $urandom_range(0, 5) == 0) begin
            burst_left = $urandom_range(1, 11) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // test sequence
   initial begin : run_tests
      for (int k = 0; k < Taps; k++) sample_hist[k] = '0;
      pred_mode = firtt_pkg::MODE_HIGH_PASS;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_high_pass_directed();
      test_low_pass_directed();
      test_mode_return();
      test_stall_fill();
      test_random_phases();
      test_back_to_back();
      repeat (2 * Latency) @(posedge clock);
      if (error_count == 0 && expected_filtered.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
